// ----- rtl/wmsd_pkg.sv -----
package wmsd_pkg;

  localparam int NCH     = 7;
  localparam int SMP_W   = 24;
  localparam int SUM_W   = 38;
  localparam int SQ_W    = 62;
  localparam int CFG_W   = 21;
  localparam int GAIN_W  = 16;
  localparam int DVD_W   = 76;
  localparam int MEAN_W  = 40;
  localparam int SIG_W   = 39;
  localparam int CH_W    = 3;
  localparam int LEN_O_W = 15;
  localparam int IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_WIN_LEN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_WIN_OFF  = 3'd1;
  localparam logic [IDX_W-1:0] REG_BUF_LEN  = 3'd2;
  localparam logic [IDX_W-1:0] REG_AMP_GAIN = 3'd3;
  localparam logic [IDX_W-1:0] REG_POS_GAIN = 3'd4;

  localparam logic [CH_W-1:0] LAST_CH   = 3'd6;
  localparam logic [CH_W-1:0] FIRST_POS = 3'd5;

  typedef struct packed {
    logic valid;
    logic clr;
  } lane_ctrl_t;

endpackage

// ----- rtl/wmsd_lane.sv -----
module wmsd_lane
  import wmsd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_ctrl_t              ctrl_i,
  input  logic signed [SMP_W-1:0] sample_i,
  output logic        [SUM_W-1:0] sum_o,
  output logic        [SQ_W-1:0]  sum_sq_o
);

  logic                      en1_q, en2_q;
  logic signed [SMP_W-1:0]   x_q, xs_q;
  logic        [2*SMP_W-1:0] sq_q;
  logic        [SUM_W-1:0]   sum_q;
  logic        [SQ_W-1:0]    sum_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en1_q    <= 1'b0;
      en2_q    <= 1'b0;
      sum_q    <= '0;
      sum_sq_q <= '0;
    end else begin
      en1_q <= ctrl_i.valid;
      en2_q <= en1_q;
      if (ctrl_i.clr) begin
        sum_q    <= '0;
        sum_sq_q <= '0;
      end else if (en2_q) begin
        sum_q    <= sum_q + SUM_W'(xs_q);
        sum_sq_q <= sum_sq_q + SQ_W'(sq_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      x_q <= sample_i;
    end
    xs_q <= x_q;
    sq_q <= (2*SMP_W)'(x_q * x_q);
  end

  assign sum_o    = sum_q;
  assign sum_sq_o = sum_sq_q;

endmodule

// ----- rtl/wmsd_div.sv -----
module wmsd_div
  import wmsd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [CFG_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [CFG_W-1:0] rem_q;
  logic [CFG_W:0]   rw;
  logic             ge;

  assign rw = {rem_q, dvd_q[DVD_W-1]};
  assign ge = (rw >= {1'b0, divisor_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? CFG_W'(rw - {1'b0, divisor_i}) : rw[CFG_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ----- rtl/wmsd_stats.sv -----
module wmsd_stats
  import wmsd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  sum_i,
  input  logic [SQ_W-1:0]   sum_sq_i,
  input  logic [CFG_W-1:0]  len_i,
  input  logic [GAIN_W-1:0] amp_gain_i,
  input  logic [GAIN_W-1:0] pos_gain_i,
  input  logic              out_ready_i,
  output logic [CH_W-1:0]   ch_o,
  output logic              out_valid_o,
  output logic [MEAN_W-1:0] mean_o,
  output logic [SIG_W-1:0]  sigma_o,
  output logic              last_o,
  output logic              clr_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_DIVM, ST_SQR, ST_DIVS, ST_DIVV,
    ST_ROOT, ST_SCALE, ST_SAT, ST_OUT
  } state_e;

  localparam int SQC_W = $clog2(SUM_W + 1);
  localparam int MM_W  = SUM_W + GAIN_W;
  localparam int SM_W  = 32 + GAIN_W;
  localparam logic [MM_W-1:0] MEAN_POS_MAX = MM_W'((64'd1 << (MEAN_W - 1)) - 64'd1);
  localparam logic [MM_W-1:0] MEAN_NEG_MAX = MM_W'(64'd1 << (MEAN_W - 1));
  localparam logic [SM_W-1:0] SIG_MAX      = SM_W'((64'd1 << SIG_W) - 64'd1);

  state_e            state_q;
  logic [CH_W-1:0]   ch_q;
  logic              neg_q;
  logic [SUM_W-1:0]  a_q, mq_q, mpl_q;
  logic [SQ_W-1:0]   sq_q;
  logic [DVD_W-1:0]  mcand_q, prod_q;
  logic [SQC_W-1:0]  sqc_q;
  logic [63:0]       v_q, r_q, bit_q;
  logic [MM_W-1:0]   mm_q;
  logic [SM_W-1:0]   sm_q;
  logic              div_start_q;
  logic [DVD_W-1:0]  div_dvd_q;
  logic              div_done;
  logic [DVD_W-1:0]  div_quo;
  logic              out_valid_q, last_q, clr_q;
  logic [MEAN_W-1:0] mean_q;
  logic [SIG_W-1:0]  sigma_q;
  logic [GAIN_W-1:0] gain;
  logic [63:0]       rt;
  logic [SUM_W-1:0]  sabs;

  assign gain = (ch_q < FIRST_POS) ? amp_gain_i : pos_gain_i;
  assign rt   = r_q + bit_q;
  assign sabs = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : sum_i;

  wmsd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dvd_q),
    .divisor_i  (len_i),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      clr_q       <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      clr_q       <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            ch_q    <= '0;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          neg_q       <= sum_i[SUM_W-1];
          a_q         <= sabs;
          sq_q        <= sum_sq_i;
          div_dvd_q   <= DVD_W'(sabs);
          div_start_q <= 1'b1;
          state_q     <= ST_DIVM;
        end
        ST_DIVM: begin
          if (div_done) begin
            mq_q    <= div_quo[SUM_W-1:0];
            prod_q  <= '0;
            mcand_q <= DVD_W'(a_q);
            mpl_q   <= a_q;
            sqc_q   <= '0;
            state_q <= ST_SQR;
          end
        end
        ST_SQR: begin
          if (mpl_q[0]) begin
            prod_q <= prod_q + mcand_q;
          end
          mcand_q <= {mcand_q[DVD_W-2:0], 1'b0};
          mpl_q   <= {1'b0, mpl_q[SUM_W-1:1]};
          sqc_q   <= sqc_q + SQC_W'(1);
          if (sqc_q == SQC_W'(SUM_W - 1)) begin
            state_q <= ST_DIVS;
          end
        end
        ST_DIVS: begin
          if (sqc_q == SQC_W'(SUM_W)) begin
            div_dvd_q   <= prod_q;
            div_start_q <= 1'b1;
            sqc_q       <= '0;
          end else if (div_done) begin
            if (DVD_W'(sq_q) > div_quo) begin
              div_dvd_q   <= DVD_W'(sq_q - div_quo[SQ_W-1:0]);
              div_start_q <= 1'b1;
              state_q     <= ST_DIVV;
            end else begin
              v_q     <= '0;
              r_q     <= '0;
              bit_q   <= 64'd1 << 62;
              state_q <= ST_ROOT;
            end
          end
        end
        ST_DIVV: begin
          if (div_done) begin
            v_q     <= 64'(div_quo[SQ_W-1:0]);
            r_q     <= '0;
            bit_q   <= 64'd1 << 62;
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (v_q >= rt) begin
            v_q <= v_q - rt;
            r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q == 64'd1) begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          mm_q    <= MM_W'(mq_q * gain);
          sm_q    <= SM_W'(r_q[31:0] * gain);
          state_q <= ST_SAT;
        end
        ST_SAT: begin
          if (neg_q) begin
            mean_q <= (mm_q > MEAN_NEG_MAX) ? MEAN_W'(-MEAN_NEG_MAX) : MEAN_W'(-mm_q);
          end else begin
            mean_q <= (mm_q > MEAN_POS_MAX) ? MEAN_W'(MEAN_POS_MAX) : MEAN_W'(mm_q);
          end
          sigma_q     <= (sm_q > SIG_MAX) ? SIG_W'(SIG_MAX) : SIG_W'(sm_q);
          last_q      <= (ch_q == LAST_CH);
          out_valid_q <= 1'b1;
          state_q     <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (ch_q == LAST_CH) begin
              clr_q   <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              ch_q    <= ch_q + CH_W'(1);
              state_q <= ST_LOAD;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign ch_o        = ch_q;
  assign out_valid_o = out_valid_q;
  assign mean_o      = mean_q;
  assign sigma_o     = sigma_q;
  assign last_o      = last_q;
  assign clr_o       = clr_q;

endmodule

// ----- rtl/windowed_mean_sigma_7ch.sv -----
// Accepts one sample request per cycle while a buffer is being collected.
// A request marked last starts the statistics: seven results follow, one per
// channel, computed in turn by the bit-serial divider, square and root unit;
// new requests wait until the seventh result is taken.
// Reset is asynchronous and active low; it restores the register defaults and
// clears the accumulators and the turn counter.
module windowed_mean_sigma_7ch
  import wmsd_pkg::*;
#(
  parameter int MAX_BUFFER = 1048576,
  parameter int MAX_WINDOW = 16384,
  parameter int MIN_WINDOW = 100
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [SMP_W-1:0]  amp_a_i,
  input  logic signed [SMP_W-1:0]  amp_b_i,
  input  logic signed [SMP_W-1:0]  amp_c_i,
  input  logic signed [SMP_W-1:0]  amp_d_i,
  input  logic signed [SMP_W-1:0]  amp_sum_i,
  input  logic signed [SMP_W-1:0]  pos_x_i,
  input  logic signed [SMP_W-1:0]  pos_y_i,
  input  logic                     last_sample_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [CH_W-1:0]          channel_o,
  output logic signed [MEAN_W-1:0] mean_scaled_o,
  output logic [SIG_W-1:0]         sigma_scaled_o,
  output logic [LEN_O_W-1:0]       eff_length_o,
  output logic [CFG_W-1:0]         eff_offset_o,
  output logic                     last_result_o
);

  localparam logic [CFG_W-1:0] BUF_CAP = CFG_W'(MAX_BUFFER);
  localparam logic [CFG_W-1:0] WIN_MAX = CFG_W'(MAX_WINDOW);
  localparam logic [CFG_W-1:0] WIN_MIN = CFG_W'(MIN_WINDOW);

  logic [CFG_W-1:0]  win_len_q, win_off_q, buf_len_q, idx_q;
  logic [GAIN_W-1:0] amp_gain_q, pos_gain_q;
  logic              busy_q, lst1_q, lst2_q;
  logic [CFG_W-1:0]  buf_c, l0, l1, len, off;
  logic [CFG_W+1:0]  lo_sum;
  logic              in_win, acc, clr;
  logic [CH_W-1:0]   ch;
  logic signed [SMP_W-1:0] smp [NCH];
  logic [SUM_W-1:0]  sums [NCH];
  logic [SQ_W-1:0]   sqs  [NCH];
  lane_ctrl_t        lctl;

  always_comb begin
    buf_c  = (buf_len_q > BUF_CAP) ? BUF_CAP : buf_len_q;
    l0     = (win_len_q > buf_c) ? buf_c : win_len_q;
    l1     = (l0 > WIN_MAX) ? WIN_MAX : l0;
    len    = (l1 < WIN_MIN) ? WIN_MIN : l1;
    lo_sum = (CFG_W+2)'(len) + (CFG_W+2)'(win_off_q);
    if (lo_sum > (CFG_W+2)'(buf_c)) begin
      off = (len > buf_c) ? '0 : CFG_W'(buf_c - len);
    end else begin
      off = win_off_q;
    end
  end

  assign in_win = (idx_q >= off) && ((CFG_W+2)'(idx_q) < (CFG_W+2)'(off) + (CFG_W+2)'(len));
  assign in_ready_o = !busy_q;
  assign acc = in_valid_i && !busy_q;
  assign lctl.valid = acc && in_win;
  assign lctl.clr   = clr;

  assign smp[0] = amp_a_i;
  assign smp[1] = amp_b_i;
  assign smp[2] = amp_c_i;
  assign smp[3] = amp_d_i;
  assign smp[4] = amp_sum_i;
  assign smp[5] = pos_x_i;
  assign smp[6] = pos_y_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q  <= CFG_W'(200);
      win_off_q  <= '0;
      buf_len_q  <= CFG_W'(100);
      amp_gain_q <= GAIN_W'(128);
      pos_gain_q <= GAIN_W'(66);
      idx_q      <= '0;
      busy_q     <= 1'b0;
      lst1_q     <= 1'b0;
      lst2_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WIN_LEN:  win_len_q  <= cfg_data_i;
          REG_WIN_OFF:  win_off_q  <= cfg_data_i;
          REG_BUF_LEN:  buf_len_q  <= cfg_data_i;
          REG_AMP_GAIN: amp_gain_q <= cfg_data_i[GAIN_W-1:0];
          REG_POS_GAIN: pos_gain_q <= cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      lst1_q <= acc && last_sample_i;
      lst2_q <= lst1_q;
      if (acc) begin
        if (last_sample_i) begin
          idx_q  <= '0;
          busy_q <= 1'b1;
        end else if (idx_q != {CFG_W{1'b1}}) begin
          idx_q <= idx_q + CFG_W'(1);
        end
      end
      if (clr) begin
        busy_q <= 1'b0;
      end
    end
  end

  for (genvar g = 0; g < NCH; g++) begin : g_lane
    wmsd_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lctl),
      .sample_i (smp[g]),
      .sum_o    (sums[g]),
      .sum_sq_o (sqs[g])
    );
  end

  wmsd_stats u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (lst2_q),
    .sum_i       (sums[ch]),
    .sum_sq_i    (sqs[ch]),
    .len_i       (len),
    .amp_gain_i  (amp_gain_q),
    .pos_gain_i  (pos_gain_q),
    .out_ready_i (out_ready_i),
    .ch_o        (ch),
    .out_valid_o (out_valid_o),
    .mean_o      (mean_scaled_o),
    .sigma_o     (sigma_scaled_o),
    .last_o      (last_result_o),
    .clr_o       (clr)
  );

  assign channel_o    = ch;
  assign eff_length_o = len[LEN_O_W-1:0];
  assign eff_offset_o = off;

endmodule
